>>> design/tps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tps_pkg
// Shared types, constants and helpers of the two-level preemptive scheduler.
// ----------------------------------------------------------------------------
package tps_pkg;

    localparam int MAX_JOBS = 64;
    localparam int SLOT_W   = $clog2(MAX_JOBS);
    localparam int CNT_W    = $clog2(MAX_JOBS + 1);
    localparam int QDEPTH   = 3 * MAX_JOBS;
    localparam int QADDR_W  = $clog2(QDEPTH);

    localparam logic OP_ARRIVAL   = 1'b0;
    localparam logic OP_TICK      = 1'b1;
    localparam logic CLASS_SYSTEM = 1'b0;
    localparam logic CLASS_USER   = 1'b1;

    typedef logic [SLOT_W-1:0]  t_slot;
    typedef logic [CNT_W-1:0]   t_cnt;
    typedef logic [QADDR_W-1:0] t_qaddr;

    typedef enum logic [1:0] {
        KIND_ACCEPT = 2'd0,
        KIND_REJECT = 2'd1,
        KIND_IDLE   = 2'd2,
        KIND_RAN    = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ALLOC,
        S_PICK,
        S_LOAD,
        S_SERVE,
        S_DONE
    } t_state;

    // Regions of the queue memory: system ring, user ring, free-slot stack
    typedef enum logic [1:0] {
        Q_SYS,
        Q_USR,
        Q_FREE
    } t_region;

    typedef struct packed {
        logic [15:0] id;
        logic [31:0] stamp;
        logic [15:0] burst;
        logic [15:0] rem;
        logic        cls;
    } t_job;

    typedef struct packed {
        logic  en;
        t_slot addr;
        t_job  data;
    } t_job_wr;

    function automatic t_qaddr q_addr(input t_region r, input t_slot idx);
        t_qaddr base;
        case (r)
            Q_SYS:   base = '0;
            Q_USR:   base = t_qaddr'(MAX_JOBS);
            default: base = t_qaddr'(2 * MAX_JOBS);
        endcase
        return base + t_qaddr'(idx);
    endfunction

    function automatic t_slot slot_inc(input t_slot s);
        return (s == t_slot'(MAX_JOBS - 1)) ? '0 : s + t_slot'(1);
    endfunction

endpackage

>>> design/tps_job_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tps_job_mem
// Job table: one entry per slot (id, arrival stamp, burst, remaining, class),
// one write port and one registered read port.
// ----------------------------------------------------------------------------
module tps_job_mem (
    input  logic            i_clk,
    input  tps_pkg::t_job_wr i_wr,
    input  logic            i_rd_en,
    input  tps_pkg::t_slot  i_rd_addr,
    output tps_pkg::t_job   o_rd_data
);
    import tps_pkg::*;

    t_job r_mem [MAX_JOBS];
    t_job r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> design/two_level_preemptive_scheduler_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_level_preemptive_scheduler_top
// Tick-driven scheduler with a system FIFO and a preemptible user FIFO.
//
//   channel  direction  handshake          fields
//   input    in         i_valid / o_stall  i_op i_job_id i_burst i_job_class
//   output   out        o_valid / i_stall  o_kind o_run_id o_finished
//                                          o_finish_time o_turnaround o_waiting
//
// An accepted arrival passes through S_ALLOC to S_DONE; a rejected one, and a
// tick when idle, go straight to S_DONE. A tick goes through S_SERVE when the
// running job continues and through S_PICK, S_LOAD and S_SERVE when a job is
// taken from a queue; the queue memory read and the job table read are both
// registered. Reset is synchronous; the memories need no clearing, slots come
// from the free-slot stack when it holds one and else from a fresh counter.
// A stalled result is held in the output register; the next item waits.
// ----------------------------------------------------------------------------
module two_level_preemptive_scheduler_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_op,
    input  logic [15:0] i_job_id,
    input  logic [15:0] i_burst,
    input  logic        i_job_class,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_kind,
    output logic [15:0] o_run_id,
    output logic        o_finished,
    output logic [31:0] o_finish_time,
    output logic [31:0] o_turnaround,
    output logic [31:0] o_waiting
);
    import tps_pkg::*;

    // Control state
    t_state r_state, n_state;
    logic   [31:0] r_now, n_now;
    t_cnt   r_slots_used, n_slots_used;
    t_cnt   r_fresh, n_fresh;
    t_cnt   r_free_cnt, n_free_cnt;
    t_slot  r_sys_head, n_sys_head, r_sys_tail, n_sys_tail;
    t_slot  r_usr_head, n_usr_head, r_usr_tail, n_usr_tail;
    t_cnt   r_sys_cnt, n_sys_cnt, r_usr_cnt, n_usr_cnt;
    logic   r_run_valid, n_run_valid;
    logic   r_from_free, n_from_free;
    logic   r_out_valid, n_out_valid;

    // Running job copy and latched arrival
    t_slot        r_run_slot, n_run_slot;
    t_job         r_run, n_run;
    logic [31:0]  r_run_due, n_run_due;
    logic [15:0]  r_in_id, n_in_id;
    logic [15:0]  r_in_burst, n_in_burst;
    logic         r_in_class, n_in_class;

    // Pending result and output register
    t_kind        r_res_kind, n_res_kind;
    logic [15:0]  r_res_id, n_res_id;
    logic         r_res_fin, n_res_fin;
    logic [31:0]  r_res_ftime, n_res_ftime;
    logic [31:0]  r_res_tat, n_res_tat;
    logic [31:0]  r_res_wait, n_res_wait;
    t_kind        r_out_kind, n_out_kind;
    logic [15:0]  r_out_id, n_out_id;
    logic         r_out_fin, n_out_fin;
    logic [31:0]  r_out_ftime, n_out_ftime;
    logic [31:0]  r_out_tat, n_out_tat;
    logic [31:0]  r_out_wait, n_out_wait;

    // Queue memory: system ring, user ring, free-slot stack
    logic [SLOT_W-1:0] r_qmem [QDEPTH];
    t_slot   r_q_rdata;
    logic    q_we, q_re;
    t_qaddr  q_waddr, q_raddr;
    t_slot   q_wdata;

    // Job table ports
    t_job_wr jm_wr;
    logic    jm_rd_en;
    t_slot   jm_rd_addr;
    t_job    jm_rd_data;

    logic        accept;
    logic        preempt;
    logic        alive;
    t_slot       alloc_slot;
    logic [15:0] serve_rem;
    logic [31:0] serve_now;
    logic        out_free;

    tps_job_mem u_job_mem (
        .i_clk     (i_clk),
        .i_wr      (jm_wr),
        .i_rd_en   (jm_rd_en),
        .i_rd_addr (jm_rd_addr),
        .o_rd_data (jm_rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (q_we) begin
            r_qmem[q_waddr] <= q_wdata;
        end
        if (q_re) begin
            r_q_rdata <= r_qmem[q_raddr];
        end
    end

    assign o_stall  = (r_state != S_IDLE);
    assign accept   = i_valid && (r_state == S_IDLE);
    assign out_free = !r_out_valid || !i_stall;
    assign preempt  = r_run_valid && (r_run.cls == CLASS_USER) && (r_sys_cnt != '0);
    assign alive    = r_run_valid && !preempt;
    assign alloc_slot = r_from_free ? r_q_rdata : t_slot'(r_fresh);
    assign serve_rem  = (r_run.rem != 16'd0) ? r_run.rem - 16'd1 : 16'd0;
    assign serve_now  = r_now + 32'd1;

    always_comb begin
        n_state      = r_state;
        n_now        = r_now;
        n_slots_used = r_slots_used;
        n_fresh      = r_fresh;
        n_free_cnt   = r_free_cnt;
        n_sys_head   = r_sys_head;
        n_sys_tail   = r_sys_tail;
        n_usr_head   = r_usr_head;
        n_usr_tail   = r_usr_tail;
        n_sys_cnt    = r_sys_cnt;
        n_usr_cnt    = r_usr_cnt;
        n_run_valid  = r_run_valid;
        n_from_free  = r_from_free;
        n_run_slot   = r_run_slot;
        n_run        = r_run;
        n_run_due    = r_run_due;
        n_in_id      = r_in_id;
        n_in_burst   = r_in_burst;
        n_in_class   = r_in_class;
        n_res_kind   = r_res_kind;
        n_res_id     = r_res_id;
        n_res_fin    = r_res_fin;
        n_res_ftime  = r_res_ftime;
        n_res_tat    = r_res_tat;
        n_res_wait   = r_res_wait;
        n_out_valid  = r_out_valid && i_stall;
        n_out_kind   = r_out_kind;
        n_out_id     = r_out_id;
        n_out_fin    = r_out_fin;
        n_out_ftime  = r_out_ftime;
        n_out_tat    = r_out_tat;
        n_out_wait   = r_out_wait;

        q_we       = 1'b0;
        q_waddr    = '0;
        q_wdata    = '0;
        q_re       = 1'b0;
        q_raddr    = '0;
        jm_wr      = '0;
        jm_rd_en   = 1'b0;
        jm_rd_addr = r_q_rdata;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_res_id    = '0;
                    n_res_fin   = 1'b0;
                    n_res_ftime = '0;
                    n_res_tat   = '0;
                    n_res_wait  = '0;
                    if (i_op == OP_ARRIVAL) begin
                        if (i_burst == 16'd0 || r_slots_used == t_cnt'(MAX_JOBS)) begin
                            n_res_kind = KIND_REJECT;
                            n_state    = S_DONE;
                        end else begin
                            // fetch a recycled slot when the free stack holds one
                            n_from_free = (r_free_cnt != '0);
                            q_re        = 1'b1;
                            q_raddr     = q_addr(Q_FREE, t_slot'(r_free_cnt - t_cnt'(1)));
                            n_in_id     = i_job_id;
                            n_in_burst  = i_burst;
                            n_in_class  = i_job_class;
                            n_state     = S_ALLOC;
                        end
                    end else begin
                        if (preempt) begin
                            // write back the user job and requeue it
                            jm_wr.en   = 1'b1;
                            jm_wr.addr = r_run_slot;
                            jm_wr.data = r_run;
                            q_we       = 1'b1;
                            q_waddr    = q_addr(Q_USR, r_usr_tail);
                            q_wdata    = r_run_slot;
                            n_usr_tail = slot_inc(r_usr_tail);
                            n_usr_cnt  = r_usr_cnt + t_cnt'(1);
                            n_run_valid = 1'b0;
                        end
                        if (alive) begin
                            n_state = S_SERVE;
                        end else if (r_sys_cnt != '0) begin
                            q_re       = 1'b1;
                            q_raddr    = q_addr(Q_SYS, r_sys_head);
                            n_sys_head = slot_inc(r_sys_head);
                            n_sys_cnt  = r_sys_cnt - t_cnt'(1);
                            n_state    = S_PICK;
                        end else if (r_usr_cnt != '0) begin
                            q_re       = 1'b1;
                            q_raddr    = q_addr(Q_USR, r_usr_head);
                            n_usr_head = slot_inc(r_usr_head);
                            n_usr_cnt  = r_usr_cnt - t_cnt'(1);
                            n_state    = S_PICK;
                        end else begin
                            n_now      = serve_now;
                            n_res_kind = KIND_IDLE;
                            n_state    = S_DONE;
                        end
                    end
                end
            end

            S_ALLOC: begin
                jm_wr.en         = 1'b1;
                jm_wr.addr       = alloc_slot;
                jm_wr.data.id    = r_in_id;
                jm_wr.data.stamp = r_now;
                jm_wr.data.burst = r_in_burst;
                jm_wr.data.rem   = r_in_burst;
                jm_wr.data.cls   = r_in_class;
                q_we    = 1'b1;
                q_wdata = alloc_slot;
                if (r_in_class == CLASS_SYSTEM) begin
                    q_waddr    = q_addr(Q_SYS, r_sys_tail);
                    n_sys_tail = slot_inc(r_sys_tail);
                    n_sys_cnt  = r_sys_cnt + t_cnt'(1);
                end else begin
                    q_waddr    = q_addr(Q_USR, r_usr_tail);
                    n_usr_tail = slot_inc(r_usr_tail);
                    n_usr_cnt  = r_usr_cnt + t_cnt'(1);
                end
                if (r_from_free) begin
                    n_free_cnt = r_free_cnt - t_cnt'(1);
                end else begin
                    n_fresh = r_fresh + t_cnt'(1);
                end
                n_slots_used = r_slots_used + t_cnt'(1);
                n_res_kind   = KIND_ACCEPT;
                n_state      = S_DONE;
            end

            S_PICK: begin
                jm_rd_en   = 1'b1;
                jm_rd_addr = r_q_rdata;
                n_run_slot = r_q_rdata;
                n_state    = S_LOAD;
            end

            S_LOAD: begin
                n_run       = jm_rd_data;
                n_run_due   = jm_rd_data.stamp + {16'd0, jm_rd_data.burst};
                n_run_valid = 1'b1;
                n_state     = S_SERVE;
            end

            S_SERVE: begin
                n_run.rem  = serve_rem;
                n_now      = serve_now;
                n_res_kind = KIND_RAN;
                n_res_id   = r_run.id;
                if (serve_rem == 16'd0) begin
                    n_res_fin   = 1'b1;
                    n_res_ftime = serve_now;
                    n_res_tat   = r_now - r_run.stamp + 32'd1;
                    n_res_wait  = r_now - r_run_due + 32'd1;
                    // release the slot onto the free stack
                    q_we         = 1'b1;
                    q_waddr      = q_addr(Q_FREE, t_slot'(r_free_cnt));
                    q_wdata      = r_run_slot;
                    n_free_cnt   = r_free_cnt + t_cnt'(1);
                    n_slots_used = r_slots_used - t_cnt'(1);
                    n_run_valid  = 1'b0;
                end
                n_state = S_DONE;
            end

            S_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_kind  = r_res_kind;
                    n_out_id    = r_res_id;
                    n_out_fin   = r_res_fin;
                    n_out_ftime = r_res_ftime;
                    n_out_tat   = r_res_tat;
                    n_out_wait  = r_res_wait;
                    n_state     = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_now        <= '0;
            r_slots_used <= '0;
            r_fresh      <= '0;
            r_free_cnt   <= '0;
            r_sys_head   <= '0;
            r_sys_tail   <= '0;
            r_usr_head   <= '0;
            r_usr_tail   <= '0;
            r_sys_cnt    <= '0;
            r_usr_cnt    <= '0;
            r_run_valid  <= 1'b0;
            r_run_slot   <= '0;
            r_from_free  <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_now        <= n_now;
            r_slots_used <= n_slots_used;
            r_fresh      <= n_fresh;
            r_free_cnt   <= n_free_cnt;
            r_sys_head   <= n_sys_head;
            r_sys_tail   <= n_sys_tail;
            r_usr_head   <= n_usr_head;
            r_usr_tail   <= n_usr_tail;
            r_sys_cnt    <= n_sys_cnt;
            r_usr_cnt    <= n_usr_cnt;
            r_run_valid  <= n_run_valid;
            r_run_slot   <= n_run_slot;
            r_from_free  <= n_from_free;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_run       <= n_run;
        r_run_due   <= n_run_due;
        r_in_id     <= n_in_id;
        r_in_burst  <= n_in_burst;
        r_in_class  <= n_in_class;
        r_res_kind  <= n_res_kind;
        r_res_id    <= n_res_id;
        r_res_fin   <= n_res_fin;
        r_res_ftime <= n_res_ftime;
        r_res_tat   <= n_res_tat;
        r_res_wait  <= n_res_wait;
        r_out_kind  <= n_out_kind;
        r_out_id    <= n_out_id;
        r_out_fin   <= n_out_fin;
        r_out_ftime <= n_out_ftime;
        r_out_tat   <= n_out_tat;
        r_out_wait  <= n_out_wait;
    end

    assign o_valid       = r_out_valid;
    assign o_kind        = r_out_kind;
    assign o_run_id      = r_out_id;
    assign o_finished    = r_out_fin;
    assign o_finish_time = r_out_ftime;
    assign o_turnaround  = r_out_tat;
    assign o_waiting     = r_out_wait;

endmodule

>>> design/tps_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tps_checker
// Port-level checks of the scheduler, bound to the top level.
// ----------------------------------------------------------------------------
module tps_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic        i_op,
    input logic [15:0] i_job_id,
    input logic [15:0] i_burst,
    input logic        i_job_class,
    input logic        o_valid,
    input logic        i_stall,
    input logic [1:0]  o_kind,
    input logic [15:0] o_run_id,
    input logic        o_finished,
    input logic [31:0] o_finish_time,
    input logic [31:0] o_turnaround,
    input logic [31:0] o_waiting
);
    import tps_pkg::*;

    // hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable({o_kind, o_run_id, o_finished,
            o_finish_time, o_turnaround, o_waiting}))
        else $error("stalled result changed");

    // one item at a time: busy after every accepted item
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("input taken again right after an accept");

    a_no_run_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_kind != KIND_RAN) |-> (o_run_id == 16'd0) && !o_finished)
        else $error("job fields on a result that served no job");

    a_no_times: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_finished |->
            (o_finish_time == 32'd0) && (o_turnaround == 32'd0) && (o_waiting == 32'd0))
        else $error("completion times without a completion");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

endmodule

bind two_level_preemptive_scheduler_top tps_checker u_tps_checker (.*);
